// ----- hw/rtl/pps_pkg.sv -----
package pps_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int TIME_BITS = 16;
  localparam int PRIO_BITS = 8;
  localparam int SLOT_BITS = $clog2(MAX_JOBS);
  localparam int CNT_BITS  = $clog2(MAX_JOBS + 1);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Request operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] burst_time;
    logic [PRIO_BITS-1:0] job_priority;
  } req_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_time;
    logic                 idle;
    logic [SLOT_BITS-1:0] ran_slot;
    logic                 finished;
    logic [TIME_BITS-1:0] turnaround;
    logic [TIME_BITS-1:0] waiting;
    logic                 all_done;
  } rsp_t;

endpackage

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
// Load transaction: accepted while idle and the block stays idle, so ready stays high; no response.
// Tick transaction: the scan, drain, update and result states run from acceptance to response and to ready again; one
// compare unit walks the 16 job slots, one slot per cycle off the job table read port.
// A finished response may wait in the output register while the next transaction is taken.
// Synchronous active-high reset empties the job table (counts) and sets time to zero;
// table contents are not cleared.
module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  state_t state;

  // Job table
  logic [TIME_BITS-1:0] arrival_mem   [MAX_JOBS];
  logic [TIME_BITS-1:0] burst_mem     [MAX_JOBS];
  logic [TIME_BITS-1:0] remaining_mem [MAX_JOBS];
  logic [PRIO_BITS-1:0] priority_mem  [MAX_JOBS];

  logic [CNT_BITS-1:0]  loaded_count;
  logic [CNT_BITS-1:0]  done_count;
  logic [TIME_BITS-1:0] current_time;

  logic [SLOT_BITS-1:0] scan_idx;

  // Read stage
  logic [TIME_BITS-1:0] rd_arr, rd_burst, rd_rem;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 cmp_valid;
  logic [SLOT_BITS-1:0] cmp_slot;

  // Best candidate so far
  logic                 found;
  logic [SLOT_BITS-1:0] best_slot;
  logic [TIME_BITS-1:0] best_arr, best_burst, best_rem;
  logic [PRIO_BITS-1:0] best_prio;

  logic                 fin;
  logic [TIME_BITS-1:0] turn;

  logic req_acc;
  logic load_we, upd_we;
  logic eligible, better;
  logic [TIME_BITS-1:0] done_at;
  logic [TIME_BITS-1:0] wait_val;

  assign req_ready = (state == ST_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign load_we   = req_acc && (req.operation == OP_LOAD) &&
                     (loaded_count < CNT_BITS'(MAX_JOBS));
  assign upd_we    = (state == ST_UPDATE) && found;

  // Candidate test for the slot just read
  assign eligible = cmp_valid && (rd_arr <= current_time) && (rd_rem != '0);
  assign better   = !found || (rd_prio < best_prio) ||
                    ((rd_prio == best_prio) && (rd_arr < best_arr));

  assign done_at  = (current_time == TIME_MAX) ? current_time : current_time + 1'b1;
  assign wait_val = (turn >= best_burst) ? turn - best_burst : '0;

  // Table writes: loads fill the next slot, ticks update remaining time
  always_ff @(posedge clk) begin
    if (load_we) begin
      arrival_mem[loaded_count[SLOT_BITS-1:0]]  <= req.arrival_time;
      burst_mem[loaded_count[SLOT_BITS-1:0]]    <= req.burst_time;
      priority_mem[loaded_count[SLOT_BITS-1:0]] <= req.job_priority;
    end
    if (load_we) begin
      remaining_mem[loaded_count[SLOT_BITS-1:0]] <= req.burst_time;
    end else if (upd_we) begin
      remaining_mem[best_slot] <= best_rem - 1'b1;
    end
  end

  // Registered table read at the scan index
  always_ff @(posedge clk) begin
    rd_arr   <= arrival_mem[scan_idx];
    rd_burst <= burst_mem[scan_idx];
    rd_rem   <= remaining_mem[scan_idx];
    rd_prio  <= priority_mem[scan_idx];
  end

  // Sequencer, compare unit and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded_count <= '0;
      done_count   <= '0;
      current_time <= '0;
      scan_idx     <= '0;
      cmp_valid    <= 1'b0;
      found        <= 1'b0;
      fin          <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // compare the slot read last cycle against the current best
      if (eligible && better) begin
        found      <= 1'b1;
        best_slot  <= cmp_slot;
        best_arr   <= rd_arr;
        best_burst <= rd_burst;
        best_rem   <= rd_rem;
        best_prio  <= rd_prio;
      end

      cmp_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (req_acc) begin
            if (req.operation == OP_TICK) begin
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end else if (load_we) begin
              loaded_count <= loaded_count + 1'b1;
              if (req.burst_time == '0) begin
                done_count <= done_count + 1'b1;
              end
            end
          end
        end

        ST_SCAN: begin
          cmp_valid <= (CNT_BITS'(scan_idx) < loaded_count);
          cmp_slot  <= scan_idx;
          if (scan_idx == SLOT_BITS'(MAX_JOBS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        ST_DRAIN: begin
          state <= ST_UPDATE;
        end

        ST_UPDATE: begin
          fin  <= found && (best_rem == TIME_BITS'(1));
          turn <= done_at - best_arr;
          if (found && (best_rem == TIME_BITS'(1))) begin
            done_count <= done_count + 1'b1;
          end
          state <= ST_RESULT;
        end

        ST_RESULT: begin
          // hold here while an earlier response is still waiting
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.now_time    <= current_time;
            rsp.idle        <= !found;
            rsp.ran_slot    <= found ? best_slot : '0;
            rsp.finished    <= fin;
            rsp.turnaround  <= fin ? turn : '0;
            rsp.waiting     <= fin ? wait_val : '0;
            rsp.all_done    <= (done_count == loaded_count);
            current_time    <= done_at;
            scan_idx        <= '0;
            state           <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pps_checker.sv -----
module pps_checker import pps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // no response straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a tick keeps the block busy on the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.operation == OP_TICK)) |=> !req_ready)
    else $error("ready straight after tick transaction");

  // idle tick reports no job details
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.idle) |->
      ((rsp.ran_slot == '0) && !rsp.finished && (rsp.turnaround == '0) &&
       (rsp.waiting == '0)))
    else $error("idle response carries job details");

  // waiting never exceeds turnaround
  a_wait_le_turn: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.finished) |-> (!rsp.idle && (rsp.waiting <= rsp.turnaround)))
    else $error("finished response inconsistent");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

// ----- tb/schedule_checker.sv -----
module schedule_checker import pps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   ticks_seen,
  output int   finishes_seen,
  output int   idles_seen,
  output int   jobs_taken
);

  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the job table
  logic [TIME_BITS-1:0] job_arrival [MAX_JOBS];
  logic [TIME_BITS-1:0] job_burst   [MAX_JOBS];
  logic [TIME_BITS-1:0] job_left    [MAX_JOBS];
  logic [PRIO_BITS-1:0] job_prio    [MAX_JOBS];
  logic [CNT_BITS-1:0]  jobs_loaded;
  logic [CNT_BITS-1:0]  jobs_done;
  logic [TIME_BITS-1:0] sim_time;

  // Tick outcomes still to come out of the block, oldest first
  rsp_t tick_results_due [$];

  initial begin
    fail_count    = 0;
    ticks_seen    = 0;
    finishes_seen = 0;
    idles_seen    = 0;
    jobs_taken    = 0;
    pending       = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Load into the next free slot; ignored once the table is full
  task automatic record_job(input req_t q);
    int slot;
    if (jobs_loaded < MAX_JOBS) begin
      slot              = int'(jobs_loaded);
      job_arrival[slot] = q.arrival_time;
      job_burst[slot]   = q.burst_time;
      job_left[slot]    = q.burst_time;
      job_prio[slot]    = q.job_priority;
      jobs_loaded       = jobs_loaded + 1'b1;
      jobs_taken++;
      // zero-length job is complete on arrival
      if (q.burst_time == '0)
        jobs_done = jobs_done + 1'b1;
    end
  endtask

  // One time unit: most urgent ready job, ties to earlier arrival then lower slot
  task automatic predict_tick(output rsp_t r);
    bit                   found;
    int                   best;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] done_at;
    logic [TIME_BITS-1:0] turn;
    found = 1'b0;
    best  = 0;
    now   = sim_time;
    r     = '0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (i >= jobs_loaded) break;
      if (job_arrival[i] > now || job_left[i] == '0) continue;
      if (!found || job_prio[i] < job_prio[best] ||
          (job_prio[i] == job_prio[best] && job_arrival[i] < job_arrival[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    r.now_time = now;
    r.idle     = !found;
    if (found) begin
      r.ran_slot     = SLOT_BITS'(best);
      job_left[best] = job_left[best] - 1'b1;
      if (job_left[best] == '0) begin
        done_at      = (now == TIME_MAX) ? now : now + 1'b1;
        turn         = done_at - job_arrival[best];
        r.finished   = 1'b1;
        r.turnaround = turn;
        r.waiting    = (turn >= job_burst[best]) ? turn - job_burst[best] : '0;
        jobs_done    = jobs_done + 1'b1;
      end
    end
    sim_time   = (now == TIME_MAX) ? now : now + 1'b1;
    r.all_done = (jobs_done == jobs_loaded);
  endtask

  // Watch both channels; the response side is handled first
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        job_arrival[i] = '0;
        job_burst[i]   = '0;
        job_left[i]    = '0;
        job_prio[i]    = '0;
      end
      jobs_loaded = '0;
      jobs_done   = '0;
      sim_time    = '0;
      tick_results_due.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (tick_results_due.size() == 0) begin
          report_mismatch("response transaction with no tick outstanding");
        end else begin
          want = tick_results_due.pop_front();
          check_field("now_time",   rsp.now_time,   want.now_time);
          check_field("idle",       rsp.idle,       want.idle);
          check_field("ran_slot",   rsp.ran_slot,   want.ran_slot);
          check_field("finished",   rsp.finished,   want.finished);
          check_field("turnaround", rsp.turnaround, want.turnaround);
          check_field("waiting",    rsp.waiting,    want.waiting);
          check_field("all_done",   rsp.all_done,   want.all_done);
        end
      end
      if (req_valid && req_ready) begin
        if (req.operation == OP_TICK) begin
          predict_tick(want);
          tick_results_due.push_back(want);
          ticks_seen++;
          if (want.idle) idles_seen++;
          if (want.finished) finishes_seen++;
        end else begin
          record_job(req);
        end
      end
    end
    pending <= tick_results_due.size();
  end

endmodule

// ----- tb/tb_preemptive_priority_scheduler.sv -----
module tb_preemptive_priority_scheduler import pps_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_CYCLES  = 600;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int fail_count;
  int pending;
  int ticks_seen;
  int finishes_seen;
  int idles_seen;
  int jobs_taken;

  int cycle_count;
  int ticks_sent;
  int loads_sent;

  preemptive_priority_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  schedule_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending       (pending),
    .ticks_seen    (ticks_seen),
    .finishes_seen (finishes_seen),
    .idles_seen    (idles_seen),
    .jobs_taken    (jobs_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d ticks outstanding", cycle_count, pending);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_load(input int arrival, input int burst, input int prio);
    req_t q;
    q.operation    = OP_LOAD;
    q.arrival_time = TIME_BITS'(arrival);
    q.burst_time   = TIME_BITS'(burst);
    q.job_priority = PRIO_BITS'(prio);
    return q;
  endfunction

  // Tick with junk in the unused fields
  function automatic req_t make_tick();
    req_t q;
    q.operation    = OP_TICK;
    q.arrival_time = TIME_BITS'($urandom);
    q.burst_time   = TIME_BITS'($urandom);
    q.job_priority = PRIO_BITS'($urandom);
    return q;
  endfunction

  // Offer one transaction after a gap and hold it until taken
  task automatic send_item(input req_t item, input int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (item.operation == OP_TICK) ticks_sent++;
    else loads_sent++;
  endtask

  // Receiver: random ready pattern with one long hold-off
  initial begin
    int  on_len;
    int  off_len;
    int  rx_cycles;
    bit  held;
    rx_cycles  = 0;
    held       = 1'b0;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      rsp_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      rx_cycles += on_len;
      off_len = pick_gap();
      if (!held && rx_cycles >= HOLD_AT) begin
        off_len = HOLD_CYCLES;
        held    = 1'b1;
      end
      if (off_len > 0) begin
        rsp_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
        rx_cycles += off_len;
      end
    end
  end

  // Sender and verdict
  initial begin
    int   useful;
    int   eager;
    int   r;
    int   burst;
    req_t item;
    ticks_sent = 0;
    loads_sent = 0;
    useful     = 0;
    eager      = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, zero-length job, then arrival and slot tie-breaks
    send_item(make_tick(), 0);
    send_item(make_load(0, 0, 0), 1);
    send_item(make_tick(), 0);
    send_item(make_load(2, 2, 255), 0);
    send_item(make_load(3, 1, 255), 2);
    send_item(make_load(3, 1, 255), 0);
    repeat (5) send_item(make_tick(), pick_gap());
    // Job that never arrives, then a low-urgency job preempted by an urgent one
    send_item(make_load(65535, 65535, 0), 0);
    send_item(make_load(8, 3, 200), 0);
    send_item(make_load(9, 1, 10), 0);
    repeat (5) send_item(make_tick(), pick_gap());

    // Random part: mostly ticks, jobs arriving near the current time
    while (useful < RANDOM_ITEMS) begin
      if (eager == 0 && $urandom_range(0, 49) == 0)
        eager = $urandom_range(20, 60);
      r = $urandom_range(0, 99);
      if (loads_sent < MAX_JOBS && r < 6) begin
        case ($urandom_range(0, 9))
          0:       burst = 0;
          1, 2, 3: burst = $urandom_range(1, 6);
          default: burst = $urandom_range(20, 120);
        endcase
        item = make_load(ticks_sent + $urandom_range(0, 60), burst, $urandom_range(0, 255));
        useful++;
      end else if (loads_sent >= MAX_JOBS && r < 12) begin
        // table full: load with arbitrary content, dropped by the block
        item = make_load($urandom, $urandom, $urandom);
        useful++;
      end else begin
        item = make_tick();
        useful++;
      end
      send_item(item, (eager > 0) ? 0 : pick_gap());
      if (eager > 0) eager--;
    end
    req_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d ticks (%0d idle, %0d completions) and %0d loads offered",
             ticks_seen, idles_seen, finishes_seen, loads_sent);
    $display("job table took %0d jobs; %0d mismatches in %0d cycles",
             jobs_taken, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
